@@ rtl/deq_pkg.sv @@
// Shared types, constants and index helpers for the double-ended queue.
// Used by deq_store, deq_ctrl and double_ended_queue; depends on nothing.
package deq_pkg;

  localparam int DEPTH       = 16;
  localparam int WORD_WIDTH  = 32;
  localparam int ADDR_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int FIELD_W     = 32;
  localparam int COUNT_OUT_W = 5;
  localparam int IN_DATA_W   = 32;
  localparam int OUT_DATA_W  = 104;
  localparam int USER_W      = 2;

  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [WORD_WIDTH-1:0]  word_t;
  typedef logic [FIELD_W-1:0]     field_t;

  localparam addr_t ADDR_LAST = ADDR_W'(DEPTH - 1);
  localparam cnt_t  CNT_FULL  = CNT_W'(DEPTH);
  localparam cnt_t  CNT_ONE   = CNT_W'(1);
  localparam cnt_t  CNT_TWO   = CNT_W'(2);

  typedef enum logic [1:0] {
    OP_PUSH_BACK  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_BACK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [0:0] {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic  we;
    addr_t waddr;
    word_t wdata;
    logic  re;
    addr_t raddr;
  } mem_req_t;

  typedef struct packed {
    status_t                status;
    field_t                 popped;
    logic [COUNT_OUT_W-1:0] count;
    field_t                 front;
    field_t                 back;
  } result_t;

  function automatic addr_t addr_inc(addr_t a);
    return (a == ADDR_LAST) ? '0 : addr_t'(a + 1'b1);
  endfunction

  function automatic addr_t addr_dec(addr_t a);
    return (a == '0) ? ADDR_LAST : addr_t'(a - 1'b1);
  endfunction

endpackage

@@ rtl/deq_store.sv @@
// Word storage for the queue: one write port and one read port with
// registered read data. Depends on deq_pkg.
module deq_store (
  input  logic              clk,
  input  deq_pkg::mem_req_t req,
  output deq_pkg::word_t    rdata
);
  import deq_pkg::*;

  word_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rdata <= mem[req.raddr];
    end
  end

endmodule

@@ rtl/deq_ctrl.sv @@
// Pointer, count and end-word control of the queue, with the sequencer that
// waits on a storage read when a pop exposes a new end word. Depends on deq_pkg.
module deq_ctrl (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  deq_pkg::op_t                   op,
  input  deq_pkg::word_t                 word,
  input  logic                           out_free,
  output logic                           res_valid,
  output deq_pkg::result_t               res,
  output deq_pkg::mem_req_t              mem_req,
  input  deq_pkg::word_t                 mem_rdata
);
  import deq_pkg::*;

  state_t state, state_next;
  addr_t  front, front_next;
  addr_t  tail, tail_next;
  cnt_t   occ, occ_next;
  word_t  front_word, front_word_next;
  word_t  back_word, back_word_next;
  word_t  pend_popped, pend_popped_next;
  logic   pend_front, pend_front_next;
  logic   accept;
  logic   need_read;
  logic   full;
  logic   empty;

  assign full   = (occ == CNT_FULL);
  assign empty  = (occ == '0);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && need_read) begin
          state_next = S_READ;
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready         = (state == S_IDLE) && out_free;
    need_read        = 1'b0;
    front_next       = front;
    tail_next        = tail;
    occ_next         = occ;
    front_word_next  = front_word;
    back_word_next   = back_word;
    pend_popped_next = pend_popped;
    pend_front_next  = pend_front;
    mem_req          = '0;
    res_valid        = 1'b0;
    res.status       = ST_DONE;
    res.popped       = '0;

    if (state == S_READ) begin
      res_valid  = 1'b1;
      res.popped = FIELD_W'(pend_popped);
      if (pend_front) begin
        front_word_next = mem_rdata;
      end else begin
        back_word_next = mem_rdata;
      end
    end else if (accept) begin
      case (op)
        OP_PUSH_BACK: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            mem_req.we     = 1'b1;
            mem_req.waddr  = addr_inc(tail);
            mem_req.wdata  = word;
            tail_next      = addr_inc(tail);
            occ_next       = occ + CNT_ONE;
            back_word_next = word;
            if (empty) begin
              front_word_next = word;
            end
          end
        end
        OP_PUSH_FRONT: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            mem_req.we      = 1'b1;
            mem_req.waddr   = addr_dec(front);
            mem_req.wdata   = word;
            front_next      = addr_dec(front);
            occ_next        = occ + CNT_ONE;
            front_word_next = word;
            if (empty) begin
              back_word_next = word;
            end
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.popped       = FIELD_W'(front_word);
            pend_popped_next = front_word;
            pend_front_next  = 1'b1;
            front_next       = addr_inc(front);
            occ_next         = occ - CNT_ONE;
            if (occ == CNT_ONE) begin
              front_word_next = '0;
              back_word_next  = '0;
            end else if (occ == CNT_TWO) begin
              front_word_next = back_word;
            end else begin
              need_read     = 1'b1;
              mem_req.re    = 1'b1;
              mem_req.raddr = addr_inc(front);
            end
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            res.status = ST_EMPTY;
          end else begin
            res.popped       = FIELD_W'(back_word);
            pend_popped_next = back_word;
            pend_front_next  = 1'b0;
            tail_next        = addr_dec(tail);
            occ_next         = occ - CNT_ONE;
            if (occ == CNT_ONE) begin
              front_word_next = '0;
              back_word_next  = '0;
            end else if (occ == CNT_TWO) begin
              back_word_next = front_word;
            end else begin
              need_read     = 1'b1;
              mem_req.re    = 1'b1;
              mem_req.raddr = addr_dec(tail);
            end
          end
        end
        default: begin
          res.status = ST_DONE;
        end
      endcase
      res_valid = !need_read;
    end

    res.count = COUNT_OUT_W'(occ_next);
    res.front = FIELD_W'(front_word_next);
    res.back  = FIELD_W'(back_word_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      front      <= '0;
      tail       <= ADDR_LAST;
      occ        <= '0;
      front_word <= '0;
      back_word  <= '0;
    end else begin
      state      <= state_next;
      front      <= front_next;
      tail       <= tail_next;
      occ        <= occ_next;
      front_word <= front_word_next;
      back_word  <= back_word_next;
    end
  end

  always_ff @(posedge clk) begin
    pend_popped <= pend_popped_next;
    pend_front  <= pend_front_next;
  end

endmodule

@@ rtl/double_ended_queue.sv @@
// Double-ended queue of DEPTH words kept as a ring buffer in one synchronous
// memory, with the front and back words cached in registers so that each
// transaction needs at most one memory read. Pushes, refused operations and
// pops that leave zero or one word need no read; a pop that leaves two or
// more words must fetch the new end word through the registered read port,
// and no transaction is taken while that read is pending. Results sit in an
// output register, and a new transaction is taken only while that register
// is empty or its result is being handed over. The storage needs no
// clearing after reset. Depends on deq_pkg, deq_store and deq_ctrl.
module double_ended_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // value [31:0]
  input  logic [deq_pkg::IN_DATA_W-1:0]   s_tdata,
  // func [1:0]
  input  logic [deq_pkg::USER_W-1:0]      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // popped_value [31:0], count_now [36:32], front_value [68:37],
  // back_value [100:69], zero [103:101]
  output logic [deq_pkg::OUT_DATA_W-1:0]  m_tdata,
  // status [1:0]
  output logic [deq_pkg::USER_W-1:0]      m_tuser
);
  import deq_pkg::*;

  mem_req_t mem_req;
  word_t    mem_rdata;
  result_t  res;
  logic     res_valid;
  logic     out_free;

  assign out_free = !m_tvalid || m_tready;

  deq_store u_store (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .op        (op_t'(s_tuser)),
    .word      (s_tdata[WORD_WIDTH-1:0]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      m_tuser <= res.status;
      m_tdata <= {3'b000, res.back, res.front, res.count, res.popped};
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> out_free)
    else $error("result produced while the output register is still held");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_FULL) |-> (res.count == COUNT_OUT_W'(DEPTH)))
    else $error("full refusal with a count below depth");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_EMPTY) |-> (res.count == '0 && res.popped == '0))
    else $error("empty refusal with a nonzero count or popped word");

  a_empty_ends: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.count == '0) |-> (res.front == '0 && res.back == '0))
    else $error("empty queue reports nonzero end words");

endmodule

@@ tb/double_ended_queue_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for double_ended_queue: directed, then random pushes and pops at
// both ends, checked against an in-bench model of the ring-buffer deque. Depends on deq_pkg.
module double_ended_queue_tb;
  import deq_pkg::*;

  localparam int LIMIT = 200000;
  localparam int N_RANDOM = 1050;

  typedef struct {
    op_t         op;
    logic [31:0] value;
  } deq_cmd_t;

  typedef struct {
    status_t     status;
    logic [31:0] popped;
    logic [4:0]  count;
    logic [31:0] front;
    logic [31:0] back;
  } deq_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  logic [USER_W-1:0]     s_tuser = '0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;
  logic [USER_W-1:0]     m_tuser;

  deq_cmd_t    cmd_q[$];
  deq_result_t exp_results[$];

  word_t q_store [DEPTH];
  addr_t q_front = '0;
  cnt_t  q_count = '0;

  int   n_cmds = 0;
  int   n_accepted = 0;
  int   n_errors = 0;
  int   cycle_cnt = 0;
  logic in_taken = 1'b0;
  int   gap_left = 0;
  int   burst_left = 0;
  int   rx_mode = 0;
  int   rx_seg = 0;
  logic hold_rx = 1'b0;

  double_ended_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #2 clk = ~clk;

  function automatic deq_result_t deq_apply(op_t op, logic [31:0] word);
    deq_result_t r;
    addr_t       slot;
    r.status = ST_DONE;
    r.popped = '0;
    r.front  = '0;
    r.back   = '0;
    case (op)
      OP_PUSH_BACK: begin
        if (q_count == CNT_FULL) begin
          r.status = ST_FULL;
        end else begin
          slot = q_front + q_count[ADDR_W-1:0];
          q_store[slot] = word;
          q_count = q_count + 1'b1;
        end
      end
      OP_PUSH_FRONT: begin
        if (q_count == CNT_FULL) begin
          r.status = ST_FULL;
        end else begin
          q_front = q_front - 1'b1;
          q_store[q_front] = word;
          q_count = q_count + 1'b1;
        end
      end
      OP_POP_FRONT: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.popped = q_store[q_front];
          q_front = q_front + 1'b1;
          q_count = q_count - 1'b1;
        end
      end
      default: begin
        if (q_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          slot = q_front + q_count[ADDR_W-1:0] - 1'b1;
          r.popped = q_store[slot];
          q_count = q_count - 1'b1;
        end
      end
    endcase
    if (q_count != 0) begin
      slot = q_front + q_count[ADDR_W-1:0] - 1'b1;
      r.front = q_store[q_front];
      r.back  = q_store[slot];
    end
    r.count = q_count;
    return r;
  endfunction

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic add_cmd(op_t op, logic [31:0] value);
    deq_cmd_t c;
    c.op = op;
    c.value = value;
    cmd_q.push_back(c);
    n_cmds++;
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(negedge clk) begin
    deq_cmd_t c;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      if (gap_left != 0) begin
        s_tvalid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cmd_q.size() != 0) begin
        c = cmd_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= c.value;
        s_tuser  <= c.op;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: readiness follows a randomly chosen duty pattern per segment.
  always @(negedge clk) begin
    if (rst || hold_rx) begin
      m_tready <= 1'b0;
    end else begin
      if (rx_seg == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_seg  <= $urandom_range(10, 80);
      end else begin
        rx_seg <= rx_seg - 1;
      end
      case (rx_mode)
        0: m_tready <= 1'b1;
        1: m_tready <= ($urandom_range(0, 3) != 0);
        2: m_tready <= 1'($urandom_range(0, 1));
        default: m_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // Long receiver hold-offs so that the block backs up and stalls its input.
  initial begin
    while (n_accepted < 300) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (150) @(posedge clk);
    hold_rx <= 1'b0;
    while (n_accepted < 750) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (120) @(posedge clk);
    hold_rx <= 1'b0;
  end

  always @(posedge clk) begin
    deq_result_t want;
    deq_result_t got;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("double_ended_queue test failed");
      $finish;
    end
    in_taken = 1'b0;
    if (!rst && s_tvalid && s_tready) begin
      exp_results.push_back(deq_apply(op_t'(s_tuser), s_tdata));
      n_accepted++;
      in_taken = 1'b1;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tuser);
      got.popped = m_tdata[31:0];
      got.count  = m_tdata[36:32];
      got.front  = m_tdata[68:37];
      got.back   = m_tdata[100:69];
      if (exp_results.size() == 0) begin
        n_errors++;
        if (n_errors <= 10)
          $display("Unexpected result transaction: status %0d popped %h count %0d",
                   got.status, got.popped, got.count);
      end else begin
        want = exp_results.pop_front();
        if (got.status !== want.status || got.popped !== want.popped ||
            got.count !== want.count || got.front !== want.front ||
            got.back !== want.back) begin
          n_errors++;
          if (n_errors <= 10) begin
            $display("Mismatch: expected st %0d pop %h cnt %0d fr %h bk %h",
                     want.status, want.popped, want.count, want.front, want.back);
            $display("          got      st %0d pop %h cnt %0d fr %h bk %h",
                     got.status, got.popped, got.count, got.front, got.back);
          end
        end
      end
    end
  end

  initial begin
    int   seg_len;
    int   seg_mode;
    logic is_push;
    add_cmd(OP_POP_FRONT, 32'h1234_5678);
    add_cmd(OP_POP_BACK, 32'hdead_beef);
    add_cmd(OP_PUSH_BACK, 32'h7fff_ffff);
    add_cmd(OP_PUSH_FRONT, 32'h8000_0000);
    add_cmd(OP_POP_BACK, 32'h0);
    add_cmd(OP_POP_BACK, 32'hffff_ffff);
    add_cmd(OP_PUSH_FRONT, 32'h0);
    add_cmd(OP_POP_FRONT, 32'h0);
    for (int i = 0; i < DEPTH; i++)
      add_cmd((i % 2 == 0) ? OP_PUSH_BACK : OP_PUSH_FRONT,
              (i % 4 == 0) ? 32'hffff_ffff : rand_word());
    add_cmd(OP_PUSH_BACK, 32'h5555_5555);
    add_cmd(OP_PUSH_FRONT, 32'haaaa_aaaa);

    // Random part in segments that lean toward filling, draining or neither.
    while (n_cmds < N_RANDOM + 26) begin
      seg_len  = $urandom_range(10, 60);
      seg_mode = $urandom_range(0, 2);
      for (int i = 0; i < seg_len; i++) begin
        case (seg_mode)
          0: is_push = ($urandom_range(0, 99) < 85);
          1: is_push = ($urandom_range(0, 99) < 15);
          default: is_push = 1'($urandom_range(0, 1));
        endcase
        if (is_push)
          add_cmd($urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK, rand_word());
        else
          add_cmd($urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT, $urandom);
      end
    end

    repeat (7) @(negedge clk);
    rst <= 1'b0;

    while (n_accepted != n_cmds) @(negedge clk);
    while (exp_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (n_errors == 0 && exp_results.size() == 0) begin
      $display("double_ended_queue test passed");
    end else begin
      $display("double_ended_queue test failed");
    end
    $finish;
  end

endmodule

@@ double_ended_queue.f @@
rtl/deq_pkg.sv
rtl/deq_store.sv
rtl/deq_ctrl.sv
rtl/double_ended_queue.sv
tb/double_ended_queue_tb.sv
